[design/pdc_pkg.sv]
// Shared types and constants for the packet destination classifier.
package pdc_pkg;

	localparam int COUNT_MAX_DEF = 65535;

	localparam int CAP_DEPTH = 24;
	localparam int CAP_IDX_W = 5;
	localparam int CLAIM_W   = 48;

	localparam int IPV4_MIN_LEN = 20;
	localparam int IPV4_PFX_LEN = 24;
	localparam int ETH_MIN_LEN  = 14;
	localparam int ETH_PFX_LEN  = 18;
	localparam int PREFIX_LEN   = 4;
	localparam int IPV4_DST_OFS = 16;

	localparam logic [3:0] IP_VERSION    = 4'h4;
	localparam logic [3:0] IHL_MIN       = 4'h5;
	localparam logic [3:0] MCAST_NIBBLE  = 4'he;

	localparam logic [1:0] MODE_IPV4 = 2'd0;
	localparam logic [1:0] MODE_ETH  = 2'd1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_BAD_ARGS = 1'b1;

	localparam logic [2:0] CLAIM_NONE = 3'd0;
	localparam logic [2:0] CLAIM_IPV4 = 3'd4;
	localparam logic [2:0] CLAIM_MAC  = 3'd6;

	typedef enum logic [2:0] {
		CLS_OK        = 3'd0,
		CLS_MALFORMED = 3'd1,
		CLS_MULTICAST = 3'd2,
		CLS_BCAST_L3  = 3'd3,
		CLS_BCAST_L2  = 3'd4
	} cls_t;

	typedef struct packed {
		logic               status;
		cls_t               classification;
		logic [CLAIM_W-1:0] claim;
		logic [2:0]         claim_bytes;
	} result_t;

endpackage

[design/packet_destination_classifier.sv]
// Top level of the packet destination classifier.
// The block takes a packet one byte per item, last_byte marking the final one,
// and gives one result per packet, queued as its last byte is taken. It accepts
// one byte every cycle while in_stall is low: the front end captures the first
// 24 bytes, keeps a saturating byte count and classifies the packet from that
// capture plus the byte in hand in the last byte's cycle, so packets may follow
// each other with no gap. Results wait in a two-entry queue, so the input
// stalls only when two results are held back by out_stall. parse_mode selects
// IPv4 tunnel (0) or Ethernet tap (1) parsing; other values give status 1.
// It may be written only while no packet is in flight; cfg_ready is always high.
module packet_destination_classifier #(
	parameter int COUNT_MAX = pdc_pkg::COUNT_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  parse_mode,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [2:0]  classification,
	output logic [47:0] claim,
	output logic [2:0]  claim_bytes
);

	logic             in_accept;
	logic             push;
	logic             q_full;
	pdc_pkg::result_t front_res;
	pdc_pkg::result_t head;

	// hold input while the queue has no room
	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;
	assign cfg_ready = 1'b1;

	pdc_front #(
		.COUNT_MAX (COUNT_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cfg_we    (cfg_valid),
		.cfg_mode  (parse_mode),
		.push      (push),
		.result    (front_res)
	);

	// advance the head when the consumer takes it
	pdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_res),
		.pop       (out_valid && !out_stall),
		.full      (q_full),
		.not_empty (out_valid),
		.head      (head)
	);

	assign status         = head.status;
	assign classification = head.classification;
	assign claim          = head.claim;
	assign claim_bytes    = head.claim_bytes;

endmodule

[design/pdc_front.sv]
// Front end: byte capture, saturating count and destination classification.
module pdc_front #(
	parameter int COUNT_MAX = pdc_pkg::COUNT_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_mode,
	output logic              push,
	output pdc_pkg::result_t  result
);

	localparam int CountW = $clog2(COUNT_MAX + 1);

	logic [CountW-1:0] count_q;
	logic [CountW-1:0] n_len;
	logic [1:0]        mode_q;
	logic [7:0]        cap_q [pdc_pkg::CAP_DEPTH];
	logic [7:0]        view  [pdc_pkg::CAP_DEPTH];

	logic        ip_off4;
	logic        ip_bad;
	logic [3:0]  ihl;
	logic [6:0]  ip_end;
	logic [31:0] ip_addr;
	logic        eth_off4;
	logic [47:0] mac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= pdc_pkg::MODE_IPV4;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_mode;
			end
			if (accept) begin
				if (last_byte) begin
					count_q <= '0;
				end else begin
					count_q <= n_len;
				end
			end
		end
	end

	// capture store, no reset: only entries of the current packet are used
	always_ff @(posedge clk) begin
		if (accept && count_q < CountW'(pdc_pkg::CAP_DEPTH)) begin
			cap_q[count_q[pdc_pkg::CAP_IDX_W-1:0]] <= data_byte;
		end
	end

	// packet as seen including the byte in hand
	always_comb begin
		for (int i = 0; i < pdc_pkg::CAP_DEPTH; i++) begin
			view[i] = (count_q == CountW'(i)) ? data_byte : cap_q[i];
		end
	end

	assign n_len = (count_q == CountW'(COUNT_MAX)) ? count_q : count_q + CountW'(1);

	// IPv4 header checks
	always_comb begin
		ip_off4 = 1'b0;
		ip_bad  = 1'b0;
		if (n_len < CountW'(pdc_pkg::IPV4_MIN_LEN)) begin
			ip_bad = 1'b1;
		end else if (view[0][7:4] != pdc_pkg::IP_VERSION) begin
			if (n_len >= CountW'(pdc_pkg::IPV4_PFX_LEN)
				&& view[pdc_pkg::PREFIX_LEN][7:4] == pdc_pkg::IP_VERSION) begin
				ip_off4 = 1'b1;
			end else begin
				ip_bad = 1'b1;
			end
		end
		ihl    = ip_off4 ? view[pdc_pkg::PREFIX_LEN][3:0] : view[0][3:0];
		ip_end = {1'b0, ihl, 2'b00} + (ip_off4 ? 7'(pdc_pkg::PREFIX_LEN) : 7'd0);
		if (ihl < pdc_pkg::IHL_MIN || CountW'(ip_end) > n_len) begin
			ip_bad = 1'b1;
		end
		if (ip_off4) begin
			ip_addr = {view[23], view[22], view[21], view[20]};
		end else begin
			ip_addr = {view[19], view[18], view[17], view[16]};
		end
	end

	// Ethernet: skip a 4-byte prefix if a packet of 18 bytes or more starts 00 00
	always_comb begin
		eth_off4 = n_len >= CountW'(pdc_pkg::ETH_PFX_LEN)
			&& view[0] == 8'h00 && view[1] == 8'h00;
		if (eth_off4) begin
			mac = {view[9], view[8], view[7], view[6], view[5], view[4]};
		end else begin
			mac = {view[5], view[4], view[3], view[2], view[1], view[0]};
		end
	end

	always_comb begin
		result.status         = pdc_pkg::STATUS_OK;
		result.classification = pdc_pkg::CLS_OK;
		result.claim          = '0;
		result.claim_bytes    = pdc_pkg::CLAIM_NONE;
		case (mode_q)
			pdc_pkg::MODE_IPV4: begin
				if (ip_bad) begin
					result.classification = pdc_pkg::CLS_MALFORMED;
				end else if (ip_addr[7:4] == pdc_pkg::MCAST_NIBBLE) begin
					result.classification = pdc_pkg::CLS_MULTICAST;
				end else begin
					result.claim       = {16'h0000, ip_addr};
					result.claim_bytes = pdc_pkg::CLAIM_IPV4;
					if (&ip_addr) begin
						result.classification = pdc_pkg::CLS_BCAST_L3;
					end
				end
			end
			pdc_pkg::MODE_ETH: begin
				if (n_len < CountW'(pdc_pkg::ETH_MIN_LEN)) begin
					result.classification = pdc_pkg::CLS_MALFORMED;
				end else if (&mac) begin
					result.classification = pdc_pkg::CLS_BCAST_L2;
				end else if (mac[0]) begin
					result.classification = pdc_pkg::CLS_MULTICAST;
				end else begin
					result.claim       = mac;
					result.claim_bytes = pdc_pkg::CLAIM_MAC;
				end
			end
			default: begin
				result.status = pdc_pkg::STATUS_BAD_ARGS;
			end
		endcase
	end

	assign push = accept && last_byte;

endmodule

[design/pdc_queue.sv]
// Two-entry result queue between the classifier and the output port.
module pdc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pdc_pkg::result_t  push_data,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output pdc_pkg::result_t  head
);

	pdc_pkg::result_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign full      = fill_q[1];
	assign not_empty = fill_q != 2'd0;
	assign head      = entry_q[rd_ptr_q];

endmodule

[tb/pdc_result_checker.sv]
// Result checker for the packet destination classifier: predicts every verdict and compares.
`timescale 1ns / 1ps
module pdc_result_checker
	import pdc_pkg::*;
#(
	parameter int COUNT_MAX = COUNT_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  parse_mode,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        status,
	input  logic [2:0]  classification,
	input  logic [47:0] claim,
	input  logic [2:0]  claim_bytes,
	output int          fail_count,
	output int          pending
);

	logic [7:0]  hdr_bytes [CAP_DEPTH];
	logic [15:0] bytes_seen;
	logic [1:0]  mode_now;
	result_t     verdict_q [$];
	result_t     want;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch, %s", $time, msg);
		fail_count++;
	endtask

	// Destination verdict for the packet held in hdr_bytes, n bytes long.
	function automatic result_t classify_packet(input logic [1:0] m, input int n);
		result_t     r;
		int          ofs;
		logic [3:0]  ihl;
		logic [31:0] dst;
		logic [47:0] mac;
		r = '0;
		r.classification = CLS_OK;
		ofs = 0;
		if (m == MODE_IPV4) begin
			if (n < IPV4_MIN_LEN) begin
				r.classification = CLS_MALFORMED;
				return r;
			end
			if (hdr_bytes[0][7:4] != IP_VERSION) begin
				if (n >= IPV4_PFX_LEN && hdr_bytes[PREFIX_LEN][7:4] == IP_VERSION) begin
					ofs = PREFIX_LEN;
				end else begin
					r.classification = CLS_MALFORMED;
					return r;
				end
			end
			ihl = hdr_bytes[ofs][3:0];
			if (ihl < IHL_MIN || ofs + 4 * int'(ihl) > n) begin
				r.classification = CLS_MALFORMED;
			end else if (hdr_bytes[ofs + IPV4_DST_OFS][7:4] == MCAST_NIBBLE) begin
				r.classification = CLS_MULTICAST;
			end else begin
				for (int i = 0; i < 4; i++) dst[8*i +: 8] = hdr_bytes[ofs + IPV4_DST_OFS + i];
				r.claim = {16'h0000, dst};
				r.claim_bytes = CLAIM_IPV4;
				r.classification = (&dst) ? CLS_BCAST_L3 : CLS_OK;
			end
		end else if (m == MODE_ETH) begin
			if (n < ETH_MIN_LEN) begin
				r.classification = CLS_MALFORMED;
				return r;
			end
			if (n >= ETH_PFX_LEN && hdr_bytes[0] == 8'h00 && hdr_bytes[1] == 8'h00)
				ofs = PREFIX_LEN;
			if (ofs + ETH_MIN_LEN > n) begin
				r.classification = CLS_MALFORMED;
				return r;
			end
			for (int i = 0; i < 6; i++) mac[8*i +: 8] = hdr_bytes[ofs + i];
			if (&mac) begin
				r.classification = CLS_BCAST_L2;
			end else if (hdr_bytes[ofs][0]) begin
				r.classification = CLS_MULTICAST;
			end else begin
				r.claim = mac;
				r.claim_bytes = CLAIM_MAC;
			end
		end else begin
			r.status = STATUS_BAD_ARGS;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (hdr_bytes[k]) hdr_bytes[k] = 8'h00;
			bytes_seen = '0;
			mode_now = MODE_IPV4;
			verdict_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("result with no packet awaiting it");
				end else begin
					want = verdict_q.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, predicted %0d",
							status, want.status));
					if (classification !== want.classification)
						report_mismatch($sformatf("classification %0d, predicted %0d",
							classification, want.classification));
					if (claim !== want.claim)
						report_mismatch($sformatf("claim %h, predicted %h",
							claim, want.claim));
					if (claim_bytes !== want.claim_bytes)
						report_mismatch($sformatf("claim_bytes %0d, predicted %0d",
							claim_bytes, want.claim_bytes));
				end
			end
			if (cfg_valid && cfg_ready) mode_now = parse_mode;
			if (in_valid && !in_stall) begin
				if (bytes_seen < CAP_DEPTH) hdr_bytes[bytes_seen] = data_byte;
				if (bytes_seen < COUNT_MAX) bytes_seen++;
				if (last_byte) begin
					verdict_q.push_back(classify_packet(mode_now, int'(bytes_seen)));
					bytes_seen = '0;
				end
			end
			pending = verdict_q.size();
		end
	end

endmodule

[tb/packet_destination_classifier_test.sv]
// Testbench top for the packet destination classifier: stimulus, idling and verdict.
`timescale 1ns / 1ps
module packet_destination_classifier_test;
	import pdc_pkg::*;

	// invalid mode codes, both expected to give bad arguments
	localparam logic [1:0] MODE_BAD_LO = 2'd2;
	localparam logic [1:0] MODE_BAD_HI = 2'd3;

	localparam int COUNT_LIMIT  = 64;      // lowest legal byte count ceiling
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 80;      // one long receiver hold-off
	localparam int PHASE_BYTES  = 80;      // byte floor for each idling phase
	localparam int LONG_PKT_LEN = 80;      // runs the byte count into saturation
	localparam int CFG_SETTLE   = 4;       // quiet cycles before a mode write
	localparam int DRAIN_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  parse_mode;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic [2:0]  classification;
	logic [47:0] claim;
	logic [2:0]  claim_bytes;

	int          fail_count;
	int          pending;
	int          tx_idle_pct = 26;
	int          rx_idle_pct = 68;
	int          cycle_count = 0;
	int          phase_bytes;
	bit          long_hold_req;
	logic [1:0]  mode_sel;
	logic [7:0]  pkt [$];

	always #5 clk = ~clk;

	packet_destination_classifier #(
		.COUNT_MAX (COUNT_LIMIT)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.parse_mode     (parse_mode),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.classification (classification),
		.claim          (claim),
		.claim_bytes    (claim_bytes)
	);

	pdc_result_checker #(
		.COUNT_MAX (COUNT_LIMIT)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.parse_mode     (parse_mode),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.classification (classification),
		.claim          (claim),
		.claim_bytes    (claim_bytes),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	// Hard stop: a hang anywhere ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: random stalls at rx_idle_pct, plus one long hold-off on request.
	// The hold-off is counted here so the sender keeps offering items meanwhile
	// and the two-entry result queue fills up and backs up the input.
	initial begin
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// Offer one item; called at a falling edge, returns at the falling edge after
	// acceptance with valid still high so back-to-back items need no toggle.
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= is_last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
		phase_bytes += pkt.size();
	endtask

	// Change parse_mode only with nothing in flight: drop valid, wait for every
	// predicted result to drain, let the block settle, then write.
	task automatic write_mode(input logic [1:0] m);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (CFG_SETTLE) @(negedge clk);
		cfg_valid  <= 1'b1;
		parse_mode <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// IPv4 packet: optional prefix (first byte never version 4), version/IHL byte,
	// destination at header offset 16, everything else random.
	task automatic build_ipv4(input int pfx, input logic [3:0] ihl,
			input logic [31:0] dst, input int len);
		int         j;
		logic [7:0] b;
		pkt.delete();
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			j = i - pfx;
			if (i < pfx) begin
				if (i == 0 && b[7:4] == IP_VERSION) b[7:4] = 4'h0;
			end else if (j == 0) begin
				b = {IP_VERSION, ihl};
			end else if (j >= IPV4_DST_OFS && j < IPV4_DST_OFS + 4) begin
				b = dst[8*(j - IPV4_DST_OFS) +: 8];
			end
			pkt.push_back(b);
		end
	endtask

	// Ethernet frame: optional prefix starting with two zero bytes, then the MAC.
	task automatic build_eth(input int pfx, input logic [47:0] mac, input int len);
		int         j;
		logic [7:0] b;
		pkt.delete();
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			j = i - pfx;
			if (i < pfx) begin
				if (i < 2) b = 8'h00;
			end else if (j < 6) begin
				b = mac[8*j +: 8];
			end
			pkt.push_back(b);
		end
	endtask

	task automatic build_noise(input int len);
		pkt.delete();
		repeat (len) pkt.push_back(8'($urandom));
	endtask

	// Mostly well-formed packets for the current mode with random content, some
	// of the other format, some pure noise; a few are cut short.
	task automatic build_random();
		int          pick;
		int          pfx;
		int          len;
		logic [3:0]  ihl;
		logic [31:0] dst;
		logic [47:0] mac;
		bit          as_ipv4;
		pick = $urandom_range(19);
		if (pick < 3) begin
			build_noise($urandom_range(30, 1));
			return;
		end
		as_ipv4 = (mode_sel == MODE_ETH) ? (pick < 7) : (pick >= 7);
		if (as_ipv4) begin
			pfx = ($urandom_range(3) == 0) ? PREFIX_LEN : 0;
			case ($urandom_range(7))
				0: ihl = 4'($urandom_range(4));
				1: ihl = 4'($urandom_range(15, 6));
				default: ihl = IHL_MIN;
			endcase
			dst = $urandom;
			case ($urandom_range(3))
				0: dst[7:4] = MCAST_NIBBLE;
				1: dst = '1;
				default: ;
			endcase
			len = pfx + ((ihl > IHL_MIN) ? 4 * ihl : IPV4_MIN_LEN) + $urandom_range(6);
			if ($urandom_range(5) == 0) len = $urandom_range(len, 1);
			build_ipv4(pfx, ihl, dst, len);
		end else begin
			pfx = ($urandom_range(2) == 0) ? PREFIX_LEN : 0;
			mac[31:0]  = $urandom;
			mac[47:32] = 16'($urandom);
			case ($urandom_range(3))
				0: mac = '1;
				1: mac[0] = 1'b1;
				default: mac[0] = 1'b0;
			endcase
			len = pfx + ETH_MIN_LEN + $urandom_range(10);
			if ($urandom_range(5) == 0) len = $urandom_range(len, 1);
			build_eth(pfx, mac, len);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		data_byte     = 8'h00;
		last_byte     = 1'b0;
		cfg_valid     = 1'b0;
		parse_mode    = MODE_IPV4;
		long_hold_req = 1'b0;
		mode_sel      = MODE_IPV4;
		phase_bytes   = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed IPv4 tunnel cases.
		write_mode(MODE_IPV4);
		build_ipv4(0, IHL_MIN, 32'h0100000a, 19);              // one byte short
		send_packet();
		build_ipv4(0, IHL_MIN, 32'h0100000a, 20);              // minimal good header
		send_packet();
		build_ipv4(0, IHL_MIN, 32'h010000e0, 20);              // multicast destination
		send_packet();
		build_ipv4(0, IHL_MIN, 32'hffffffff, 20);              // all-ones broadcast
		send_packet();
		build_ipv4(0, 4'h4, 32'h0100000a, 20);                 // IHL below minimum
		send_packet();
		build_ipv4(0, 4'hf, 32'h0100000a, 20);                 // header runs past the end
		send_packet();
		build_ipv4(0, 4'hf, 32'h0100000a, 60);                 // largest header, exact fit
		send_packet();
		build_ipv4(PREFIX_LEN, IHL_MIN, 32'h0201a8c0, 24);     // tunnel prefix, good
		send_packet();
		build_ipv4(PREFIX_LEN, IHL_MIN, 32'h0201a8c0, 23);     // prefix but too short
		send_packet();
		build_ipv4(PREFIX_LEN, IHL_MIN, 32'h0201a8c0, 30);     // no version 4 at either offset
		pkt[PREFIX_LEN][7:4] = 4'h6;
		send_packet();
		build_noise(1);                                        // single-byte packets
		pkt[0] = 8'hff;
		send_packet();
		pkt[0] = 8'h00;
		send_packet();

		// Directed Ethernet tap cases.
		write_mode(MODE_ETH);
		mode_sel = MODE_ETH;
		build_eth(0, 48'h665544332210, 13);                    // too short
		send_packet();
		build_eth(0, 48'h665544332210, 14);                    // unicast, minimal
		send_packet();
		build_eth(0, 48'hffffffffffff, 14);                    // L2 broadcast
		send_packet();
		build_eth(0, 48'h665544332201, 14);                    // group bit set
		send_packet();
		build_eth(PREFIX_LEN, 48'h665544332210, 18);           // prefix skipped
		send_packet();
		build_eth(0, 48'h665544330000, 17);                    // zero bytes, too short to skip
		send_packet();
		build_eth(0, 48'h665544330000, 18);                    // zero bytes taken as prefix
		send_packet();

		// Both invalid modes.
		write_mode(MODE_BAD_LO);
		build_eth(0, 48'h665544332210, 14);
		send_packet();
		write_mode(MODE_BAD_HI);
		build_noise(1);
		send_packet();

		// Random part in three idling phases: sender light / receiver heavy,
		// then swapped, then no idling at all.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 26;
					rx_idle_pct = 68;
				end
				1: begin
					tx_idle_pct = 68;
					rx_idle_pct = 26;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				case ($urandom_range(9))
					0, 1, 2, 3: mode_sel = MODE_IPV4;
					4, 5, 6, 7: mode_sel = MODE_ETH;
					8: mode_sel = MODE_BAD_LO;
					default: mode_sel = MODE_BAD_HI;
				endcase
				write_mode(mode_sel);
				repeat ($urandom_range(10, 4)) begin
					build_random();
					send_packet();
				end
				// Hold the receiver off and keep feeding one-byte packets so the
				// result queue fills and the input stalls.
				if (ph == 0 && !long_hold_req) begin
					long_hold_req <= 1'b1;
					repeat (12) begin
						build_noise(1);
						send_packet();
					end
				end
			end
		end

		// One long good packet: the byte count saturates, verdict unchanged.
		mode_sel = MODE_IPV4;
		write_mode(mode_sel);
		build_ipv4(0, IHL_MIN, $urandom, LONG_PKT_LEN);
		send_packet();
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
